@@ src/hdlc_nrzi_bit_encoder_with_fcs_defines.svh @@
// ----------------------------------------------------------------------------
// HDLC NRZI encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HDLC_NRZI_BIT_ENCODER_WITH_FCS_DEFINES_SVH
`define HDLC_NRZI_BIT_ENCODER_WITH_FCS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HNFE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HNFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hnfe_pkg.sv @@
// ----------------------------------------------------------------------------
// HDLC NRZI encoder package
// Types, constants and the CRC-16 bit update shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hnfe_pkg;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_START = 2'd1,
        OP_CRC   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_START = 2'd1,
        CMD_CRC   = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } qentry_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_BITS  = 2'd1,
        BK_STUFF = 2'd2
    } bk_state_t;

    typedef struct packed {
        logic        pop;
        logic        busy;
        logic [15:0] crc;
    } bk_status_t;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [2:0]  STUFF_LIMIT = 3'd5;
    localparam int          QUEUE_DEPTH = 2;
    localparam int          QPTR_W      = 1;
    localparam int          QCNT_W      = 2;

    function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic din);
        logic [15:0] shifted;
        shifted = {1'b0, crc[15:1]};
        crc_bit = (crc[0] ^ din) ? (shifted ^ CRC_POLY) : shifted;
    endfunction

endpackage

`default_nettype wire

@@ src/hnfe_front.sv @@
// ----------------------------------------------------------------------------
// HDLC NRZI encoder front end
// Accepts input transfers, decodes the operation and hands commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hnfe_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        op,
    input  wire logic [7:0]        data_byte,
    input  wire logic              q_full,
    output logic                   q_push,
    output hnfe_pkg::qentry_t      q_entry
);

    logic              front_valid_reg;
    logic              front_valid_next;
    hnfe_pkg::qentry_t entry_reg;
    hnfe_pkg::qentry_t entry_next;
    hnfe_pkg::qentry_t decoded;
    logic              keep;
    logic              accept;

    assign in_stall = front_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = front_valid_reg && !q_full;
    assign q_entry  = entry_reg;

    always_comb
    begin
        decoded.data = data_byte;
        decoded.cmd  = hnfe_pkg::CMD_SEND;
        keep         = 1'b1;
        unique case (hnfe_pkg::op_t'(op))
            hnfe_pkg::OP_SEND:
            begin
                decoded.cmd = hnfe_pkg::CMD_SEND;
            end
            hnfe_pkg::OP_START:
            begin
                decoded.cmd = hnfe_pkg::CMD_START;
            end
            hnfe_pkg::OP_CRC:
            begin
                decoded.cmd = hnfe_pkg::CMD_CRC;
            end
            hnfe_pkg::OP_NONE:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        entry_next       = entry_reg;
        if (accept)
        begin
            front_valid_next = keep;
            entry_next       = decoded;
        end
        else if (q_push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ src/hnfe_queue.sv @@
// ----------------------------------------------------------------------------
// HDLC NRZI encoder command queue
// Short register FIFO that decouples the front end from the symbol engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hnfe_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire hnfe_pkg::qentry_t          wr_entry,
    input  wire logic                       pop,
    output hnfe_pkg::qentry_t               head,
    output logic                            full,
    output logic                            empty,
    output logic [hnfe_pkg::QCNT_W-1:0]     count
);

    localparam logic [hnfe_pkg::QPTR_W-1:0] LAST_PTR =
        hnfe_pkg::QPTR_W'(hnfe_pkg::QUEUE_DEPTH - 1);
    localparam logic [hnfe_pkg::QCNT_W-1:0] DEPTH_CNT =
        hnfe_pkg::QCNT_W'(hnfe_pkg::QUEUE_DEPTH);

    hnfe_pkg::qentry_t                entries_reg [hnfe_pkg::QUEUE_DEPTH];
    logic [hnfe_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [hnfe_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [hnfe_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [hnfe_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [hnfe_pkg::QCNT_W-1:0]      count_reg;
    logic [hnfe_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign head    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

@@ src/hnfe_back.sv @@
// ----------------------------------------------------------------------------
// HDLC NRZI encoder symbol engine
// Serializes queued commands into NRZI tone symbols with bit stuffing and CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module hnfe_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire hnfe_pkg::qentry_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   tone,
    output logic                   stuffed,
    output logic                   last,
    output hnfe_pkg::bk_status_t   status
);

    hnfe_pkg::bk_state_t state_reg;
    hnfe_pkg::bk_state_t state_next;
    logic [15:0]         crc_reg;
    logic [15:0]         crc_next;
    logic [2:0]          ones_reg;
    logic [2:0]          ones_next;
    logic                tone_reg;
    logic                tone_next;
    logic [7:0]          byte_reg;
    logic [7:0]          byte_next;
    logic [7:0]          hi_reg;
    logic [7:0]          hi_next;
    logic                second_reg;
    logic                second_next;
    logic [2:0]          idx_reg;
    logic [2:0]          idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_tone_reg;
    logic                out_tone_next;
    logic                out_stuffed_reg;
    logic                out_stuffed_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic                ob_free;
    logic                cur_bit;
    logic                is_flag;
    logic [2:0]          ones_eff;
    logic [2:0]          ones_inc;
    logic                stuff_now;
    logic                byte_end;

    assign ob_free   = !out_valid_reg || !out_stall;
    assign cur_bit   = byte_reg[idx_reg];
    assign is_flag   = (byte_reg == hnfe_pkg::FLAG_BYTE);
    assign ones_eff  = is_flag ? 3'd0 : ones_reg;
    assign ones_inc  = ones_eff + 3'd1;
    assign stuff_now = cur_bit && (ones_inc == hnfe_pkg::STUFF_LIMIT);
    assign byte_end  = (idx_reg == 3'd7);

    assign out_valid = out_valid_reg;
    assign tone      = out_tone_reg;
    assign stuffed   = out_stuffed_reg;
    assign last      = out_last_reg;

    assign status.pop  = q_pop;
    assign status.busy = (state_reg != hnfe_pkg::BK_IDLE);
    assign status.crc  = crc_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hnfe_pkg::BK_IDLE:
            begin
                if (!q_empty && (q_head.cmd != hnfe_pkg::CMD_START))
                begin
                    state_next = hnfe_pkg::BK_BITS;
                end
            end
            hnfe_pkg::BK_BITS:
            begin
                if (ob_free)
                begin
                    if (stuff_now)
                    begin
                        state_next = hnfe_pkg::BK_STUFF;
                    end
                    else if (byte_end && !second_reg)
                    begin
                        state_next = hnfe_pkg::BK_IDLE;
                    end
                end
            end
            hnfe_pkg::BK_STUFF:
            begin
                if (ob_free)
                begin
                    if (byte_end && !second_reg)
                    begin
                        state_next = hnfe_pkg::BK_IDLE;
                    end
                    else
                    begin
                        state_next = hnfe_pkg::BK_BITS;
                    end
                end
            end
            default:
            begin
                state_next = hnfe_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop            = 1'b0;
        crc_next         = crc_reg;
        ones_next        = ones_reg;
        tone_next        = tone_reg;
        byte_next        = byte_reg;
        hi_next          = hi_reg;
        second_next      = second_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_tone_next    = out_tone_reg;
        out_stuffed_next = out_stuffed_reg;
        out_last_next    = out_last_reg;
        unique case (state_reg)
            hnfe_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.cmd)
                        hnfe_pkg::CMD_START:
                        begin
                            crc_next = hnfe_pkg::CRC_INIT;
                        end
                        hnfe_pkg::CMD_SEND:
                        begin
                            byte_next   = q_head.data;
                            second_next = 1'b0;
                            idx_next    = 3'd0;
                        end
                        hnfe_pkg::CMD_CRC:
                        begin
                            byte_next   = ~crc_reg[7:0];
                            hi_next     = ~crc_reg[15:8];
                            second_next = 1'b1;
                            idx_next    = 3'd0;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            hnfe_pkg::BK_BITS:
            begin
                if (ob_free)
                begin
                    if (!is_flag)
                    begin
                        crc_next = hnfe_pkg::crc_bit(crc_reg, cur_bit);
                    end
                    out_valid_next   = 1'b1;
                    out_stuffed_next = 1'b0;
                    out_last_next    = byte_end && !second_reg && !stuff_now;
                    if (!cur_bit)
                    begin
                        tone_next     = ~tone_reg;
                        out_tone_next = ~tone_reg;
                        ones_next     = 3'd0;
                    end
                    else
                    begin
                        out_tone_next = tone_reg;
                        ones_next     = ones_inc;
                    end
                    if (!stuff_now)
                    begin
                        idx_next = idx_reg + 3'd1;
                        if (byte_end && second_reg)
                        begin
                            byte_next   = hi_reg;
                            second_next = 1'b0;
                        end
                    end
                end
            end
            hnfe_pkg::BK_STUFF:
            begin
                if (ob_free)
                begin
                    tone_next        = ~tone_reg;
                    ones_next        = 3'd0;
                    out_valid_next   = 1'b1;
                    out_tone_next    = ~tone_reg;
                    out_stuffed_next = 1'b1;
                    out_last_next    = byte_end && !second_reg;
                    idx_next         = idx_reg + 3'd1;
                    if (byte_end && second_reg)
                    begin
                        byte_next   = hi_reg;
                        second_next = 1'b0;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hnfe_pkg::BK_IDLE;
            crc_reg       <= hnfe_pkg::CRC_INIT;
            ones_reg      <= 3'd0;
            tone_reg      <= 1'b0;
            second_reg    <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            ones_reg      <= ones_next;
            tone_reg      <= tone_next;
            second_reg    <= second_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        hi_reg          <= hi_next;
        out_tone_reg    <= out_tone_next;
        out_stuffed_reg <= out_stuffed_next;
        out_last_reg    <= out_last_next;
    end

endmodule

`default_nettype wire

@@ src/hdlc_nrzi_bit_encoder_with_fcs.sv @@
// ----------------------------------------------------------------------------
// HDLC NRZI bit encoder with FCS
// Input commands carry an op and a data byte; op 0 sends the byte, op 1 starts
// a frame by setting the CRC-16 to all ones, op 2 sends the complemented CRC
// low byte first, and op 3 is dropped. Each output transfer is one tone symbol
// with a stuffed mark and a last mark on the final symbol of a command.
// Bytes leave least significant bit first; five ones in a row add a stuffing
// symbol, and the flag byte 0x7E is neither stuffed nor added to the CRC.
// A command passes a front register, a two-entry queue and the engine's byte
// register before its first symbol is registered at the output.
// The symbol engine makes one symbol per cycle while the output is not stalled
// and loads each command in its idle state; a start command only sets the CRC
// and makes no symbol.
// When the receiver stalls, the symbol holds and the engine waits; the queue
// and front register keep accepting until they fill, then in_stall rises.
// Reset empties the queue and output, sets the CRC to all ones, the ones count
// to zero and the tone to 1200 Hz.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hdlc_nrzi_bit_encoder_with_fcs_defines.svh"

module hdlc_nrzi_bit_encoder_with_fcs (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            tone,
    output logic            stuffed,
    output logic            last
);

    logic                            q_full;
    logic                            q_empty;
    logic                            q_push;
    logic                            q_pop;
    logic [hnfe_pkg::QCNT_W-1:0]     q_count;
    hnfe_pkg::qentry_t               q_wr_entry;
    hnfe_pkg::qentry_t               q_head;
    hnfe_pkg::bk_status_t            bk_status;

    hnfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_wr_entry)
    );

    hnfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty),
        .count    (q_count)
    );

    hnfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tone      (tone),
        .stuffed   (stuffed),
        .last      (last),
        .status    (bk_status)
    );

    `HNFE_ASSERT_IMPL(a_pop_not_empty, bk_status.pop, q_count != '0,
        "command popped from an empty queue")
    `HNFE_ASSERT_NEXT(a_start_sets_crc,
        bk_status.pop && q_head.cmd == hnfe_pkg::CMD_START,
        bk_status.crc == hnfe_pkg::CRC_INIT, "start command did not reset the CRC")
    `HNFE_ASSERT_IMPL(a_symbol_from_busy, $rose(out_valid), $past(bk_status.busy),
        "symbol presented while the engine was idle")

endmodule

`default_nettype wire

@@ tb/sv/hdlc_nrzi_bit_encoder_with_fcs_tb.sv @@
// ----------------------------------------------------------------------------
// HDLC NRZI bit encoder with FCS testbench
// Drives frames of start, data, flag and FCS commands into the encoder and
// checks every tone symbol against an in-bench model of the NRZI coding, the
// bit stuffing and the CRC-16. Both sides idle at random, with one long
// receiver hold-off that fills the encoder and full drains of the output.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_nrzi_bit_encoder_with_fcs_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hnfe_pkg::*;

    localparam int RANDOM_ITEMS   = 280;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;

    class fcs_symbol_scoreboard;
        typedef struct packed {
            logic tone;
            logic stuffed;
            logic last;
        } symbol_t;

        symbol_t     expected_symbols[$];
        logic [15:0] fcs_reg;
        logic [2:0]  ones_run;
        logic        line_tone;
        int          mismatches;
        int          symbols_checked;
        int          stuff_symbols;
        int          flags_sent;
        int          op_counts[4];

        function new();
            fcs_reg = CRC_INIT;
            ones_run = 3'd0;
            line_tone = 1'b0;
            mismatches = 0;
            symbols_checked = 0;
            stuff_symbols = 0;
            flags_sent = 0;
            for (int i = 0; i < 4; i++)
                op_counts[i] = 0;
        endfunction

        static function logic [15:0] fcs_after_byte(logic [15:0] c, logic [7:0] b);
            logic mix;
            if (b != FLAG_BYTE) begin
                for (int i = 0; i < 8; i++) begin
                    mix = c[0] ^ b[i];
                    c = {1'b0, c[15:1]};
                    if (mix)
                        c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void encode_byte(logic [7:0] b);
            symbol_t sym;
            if (b == FLAG_BYTE)
                flags_sent++;
            for (int i = 0; i < 8; i++) begin
                if (b == FLAG_BYTE)
                    ones_run = 3'd0;
                if (!b[i]) begin
                    line_tone = ~line_tone;
                    sym = '{tone: line_tone, stuffed: 1'b0, last: 1'b0};
                    expected_symbols.push_back(sym);
                    ones_run = 3'd0;
                end
                else begin
                    sym = '{tone: line_tone, stuffed: 1'b0, last: 1'b0};
                    expected_symbols.push_back(sym);
                    ones_run = ones_run + 3'd1;
                    if (ones_run >= STUFF_LIMIT) begin
                        line_tone = ~line_tone;
                        sym = '{tone: line_tone, stuffed: 1'b1, last: 1'b0};
                        expected_symbols.push_back(sym);
                        ones_run = 3'd0;
                    end
                end
            end
            fcs_reg = fcs_after_byte(fcs_reg, b);
        endfunction

        function void note_input(op_t o, logic [7:0] b);
            int      before_count;
            logic [7:0] fcs_lo;
            logic [7:0] fcs_hi;
            symbol_t sym;
            before_count = expected_symbols.size();
            op_counts[o]++;
            case (o)
                OP_SEND:
                    encode_byte(b);
                OP_START:
                    fcs_reg = CRC_INIT;
                OP_CRC:
                begin
                    fcs_lo = ~fcs_reg[7:0];
                    fcs_hi = ~fcs_reg[15:8];
                    encode_byte(fcs_lo);
                    encode_byte(fcs_hi);
                end
                default:
                    ;
            endcase
            if (expected_symbols.size() > before_count) begin
                sym = expected_symbols.pop_back();
                sym.last = 1'b1;
                expected_symbols.push_back(sym);
            end
        endfunction

        function int pending();
            return expected_symbols.size();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_symbol(logic t, logic s, logic l);
            symbol_t exp_sym;
            if (expected_symbols.size() == 0) begin
                report($sformatf("symbol tone=%b stuffed=%b last=%b with none expected",
                                 t, s, l));
                return;
            end
            exp_sym = expected_symbols.pop_front();
            symbols_checked++;
            if (s === 1'b1)
                stuff_symbols++;
            if (t !== exp_sym.tone)
                report($sformatf("symbol %0d tone %b, expected %b",
                                 symbols_checked, t, exp_sym.tone));
            if (s !== exp_sym.stuffed)
                report($sformatf("symbol %0d stuffed %b, expected %b",
                                 symbols_checked, s, exp_sym.stuffed));
            if (l !== exp_sym.last)
                report($sformatf("symbol %0d last %b, expected %b",
                                 symbols_checked, l, exp_sym.last));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    logic       tone;
    logic       stuffed;
    logic       last;

    fcs_symbol_scoreboard sb;
    logic hold_req;
    int   burst_left;
    int   random_count;

    hdlc_nrzi_bit_encoder_with_fcs u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tone      (tone),
        .stuffed   (stuffed),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(op_t'(op), data_byte);
        if (rst_n && out_valid && !out_stall)
            sb.check_symbol(tone, stuffed, last);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("hdlc_nrzi_bit_encoder_with_fcs_tb: errors");
        $finish;
    end

    initial
    begin
        int mode;
        int run_left;
        int phase;
        logic stall_next;
        out_stall = 1'b0;
        run_left = 0;
        mode = 0;
        phase = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (run_left == 0) begin
                mode = $urandom_range(0, 3);
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            phase++;
            case (mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = ($urandom_range(0, 1) == 0);
                default: stall_next = ((phase % 4) == 3);
            endcase
            out_stall <= stall_next;
        end
    end

    task automatic offer(input op_t o, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= o;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (o != OP_NONE)
            random_count++;
    endtask

    task automatic drain_output();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'hFF ^ (8'h01 << $urandom_range(0, 7));
            1: return FLAG_BYTE;
            2: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int n_bytes);
        offer(OP_START, 8'($urandom_range(0, 255)));
        for (int i = 0; i < n_bytes; i++)
            offer(OP_SEND, pick_byte());
        offer(OP_CRC, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [15:0] fcs_probe;
        logic [15:0] flag_pair;
        int          n_noise;
        logic        pressure_done;
        logic        drain_done;

        sb = new();
        in_valid = 1'b0;
        op = OP_SEND;
        data_byte = 8'h00;
        rst_n = 1'b0;
        hold_req = 1'b0;
        burst_left = 0;
        random_count = 0;
        pressure_done = 1'b0;
        drain_done = 1'b0;

        flag_pair = 16'h0000;
        for (int k = 0; k < 65536; k++) begin
            fcs_probe = fcs_symbol_scoreboard::fcs_after_byte(
                fcs_symbol_scoreboard::fcs_after_byte(CRC_INIT, k[7:0]), k[15:8]);
            if ((~fcs_probe[7:0]) == FLAG_BYTE || (~fcs_probe[15:8]) == FLAG_BYTE) begin
                flag_pair = k[15:0];
                break;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, stuffing inside and across bytes, flags after a run of ones,
        // the dropped op, an empty frame and an FCS byte that equals the flag.
        offer(OP_START, 8'h00);
        offer(OP_SEND, 8'h00);
        offer(OP_SEND, 8'hFF);
        offer(OP_SEND, FLAG_BYTE);
        offer(OP_SEND, 8'h1F);
        offer(OP_SEND, 8'hF8);
        offer(OP_CRC, 8'hFF);
        offer(OP_NONE, 8'h5A);
        offer(OP_START, 8'hFF);
        offer(OP_SEND, 8'h80);
        offer(OP_SEND, 8'h0F);
        offer(OP_SEND, 8'hF0);
        offer(OP_SEND, FLAG_BYTE);
        offer(OP_SEND, 8'h55);
        offer(OP_SEND, 8'hAA);
        offer(OP_CRC, 8'h00);
        offer(OP_START, 8'hA5);
        offer(OP_CRC, 8'h3C);
        offer(OP_NONE, 8'hC3);
        offer(OP_START, 8'h00);
        offer(OP_SEND, flag_pair[7:0]);
        offer(OP_SEND, flag_pair[15:8]);
        offer(OP_CRC, 8'h00);
        drain_output();

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            if (!pressure_done && random_count >= 100) begin
                pressure_done = 1'b1;
                hold_req = 1'b1;
                burst_left = 40;
                send_frame(10);
            end
            else if (!drain_done && random_count >= 200) begin
                drain_done = 1'b1;
                drain_output();
            end
            else if ($urandom_range(0, 9) < 8) begin
                send_frame($urandom_range(1, 6));
            end
            else begin
                n_noise = $urandom_range(1, 3);
                for (int i = 0; i < n_noise; i++)
                    offer(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        drain_output();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes (%0d flag bytes), %0d frame starts, %0d FCS commands and %0d unused ops.",
                 sb.op_counts[OP_SEND], sb.flags_sent, sb.op_counts[OP_START],
                 sb.op_counts[OP_CRC], sb.op_counts[OP_NONE]);
        $display("Compared %0d tone symbols, %0d of them stuffing symbols.",
                 sb.symbols_checked, sb.stuff_symbols);
        if (sb.mismatches == 0)
            $display("hdlc_nrzi_bit_encoder_with_fcs_tb: clean");
        else
            $display("hdlc_nrzi_bit_encoder_with_fcs_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
